// ===== hdl/m4mul_pkg.sv =====
// ----------------------------------------------------------------------------
// m4mul_pkg
// Shared constants and types for the 4x4 fixed-point matrix multiplier.
// ----------------------------------------------------------------------------
package m4mul_pkg;

	localparam int DIM       = 4;
	localparam int FRAC_BITS = 16;
	localparam int CELLS     = DIM * DIM;

	localparam int DATA_W   = 32;
	localparam int IDX_IN_W = 4;
	localparam int ADDR_W   = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int RC_W     = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int PROD_W   = 2 * DATA_W;
	localparam int ACC_W    = PROD_W - FRAC_BITS + RC_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic              valid;
		logic              first;
		logic              last;
		logic [ADDR_W-1:0] a_addr;
		logic [ADDR_W-1:0] b_addr;
		logic [ADDR_W-1:0] flat;
		logic              final_cell;
	} issue_t;

endpackage

// ===== hdl/mat4_multiply_top.sv =====
// ----------------------------------------------------------------------------
// mat4_multiply_top
// 4x4 signed Q16.16 matrix multiplier, C = A * B, column-major flat indexes.
//
// Input: a beat is taken at a rising edge with start high and busy low.
//   func selects the A (0) or B (1) store, element_index is col*4+row.
//   A beat with compute_now low only stores its element; busy stays low,
//   so loads go at one per cycle.
//   A beat with compute_now high stores its element and starts the product.
//   busy then stays high until the last result is out: the sequencer issues 64
//   multiply-accumulates, one per cycle, through a single 32x32 multiplier,
//   and the pipeline (store read, multiply, accumulate) then drains.
// Output: 16 result beats in flat-index order, each shown for one cycle with
//   result_valid high, one per four-term sum. last_result marks the
//   sixteenth. The receiver cannot stall the block; results must be taken.
// Products are floored after the shift by 16; sums saturate to 32 bits.
// Reset: arst_n clears the sequencer and strobes; store contents are
//   undefined until written and every entry must be loaded before use.
// ----------------------------------------------------------------------------
module mat4_multiply_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                func,
	input  logic [m4mul_pkg::IDX_IN_W-1:0]      element_index,
	input  logic signed [m4mul_pkg::DATA_W-1:0] element_value,
	input  logic                                compute_now,
	output logic                                result_valid,
	output logic [m4mul_pkg::IDX_IN_W-1:0]      result_index,
	output logic signed [m4mul_pkg::DATA_W-1:0] result_value,
	output logic                                last_result
);
	import m4mul_pkg::*;

	logic                     accept;
	logic                     in_range;
	logic [ADDR_W-1:0]        wr_addr;
	issue_t                   issue;
	logic signed [DATA_W-1:0] a_s1;
	logic signed [DATA_W-1:0] b_s1;

	assign accept   = start && !busy;
	assign in_range = (32'(element_index) < CELLS);
	assign wr_addr  = ADDR_W'(element_index);

	m4mul_store u_store_a (
		.clk     (clk),
		.wr_en   (accept && in_range && !func),
		.wr_addr (wr_addr),
		.wr_data (element_value),
		.rd_addr (issue.a_addr),
		.rd_data (a_s1)
	);

	m4mul_store u_store_b (
		.clk     (clk),
		.wr_en   (accept && in_range && func),
		.wr_addr (wr_addr),
		.wr_data (element_value),
		.rd_addr (issue.b_addr),
		.rd_data (b_s1)
	);

	m4mul_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (accept && compute_now),
		.drain_done (result_valid && last_result),
		.busy       (busy),
		.issue      (issue)
	);

	m4mul_mac u_mac (
		.clk          (clk),
		.arst_n       (arst_n),
		.issue        (issue),
		.a_s1         (a_s1),
		.b_s1         (b_s1),
		.result_valid (result_valid),
		.result_index (result_index),
		.result_value (result_value),
		.last_result  (last_result)
	);

endmodule

// ===== hdl/m4mul_store.sv =====
// ----------------------------------------------------------------------------
// m4mul_store
// Element store for one matrix: one write port, one registered read port.
// ----------------------------------------------------------------------------
module m4mul_store (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [m4mul_pkg::ADDR_W-1:0]           wr_addr,
	input  logic signed [m4mul_pkg::DATA_W-1:0]    wr_data,
	input  logic [m4mul_pkg::ADDR_W-1:0]           rd_addr,
	output logic signed [m4mul_pkg::DATA_W-1:0]    rd_data
);
	import m4mul_pkg::*;

	logic signed [DATA_W-1:0] mem [CELLS];
	logic signed [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/m4mul_mac.sv =====
// ----------------------------------------------------------------------------
// m4mul_mac
// Shared multiply-accumulate unit: one product per cycle, floor shift,
// running sum and saturation, with the registered result port.
// ----------------------------------------------------------------------------
module m4mul_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  m4mul_pkg::issue_t                   issue,
	input  logic signed [m4mul_pkg::DATA_W-1:0] a_s1,
	input  logic signed [m4mul_pkg::DATA_W-1:0] b_s1,
	output logic                                result_valid,
	output logic [m4mul_pkg::IDX_IN_W-1:0]      result_index,
	output logic signed [m4mul_pkg::DATA_W-1:0] result_value,
	output logic                                last_result
);
	import m4mul_pkg::*;

	issue_t                   issue_s1;
	issue_t                   issue_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [PROD_W-1:0] term_c;
	logic signed [ACC_W-1:0]  sum_c;
	logic [ACC_W-DATA_W:0]    hi_c;
	logic [DATA_W-1:0]        sat_c;

	logic                     valid_q;
	logic                     last_q;
	logic [IDX_IN_W-1:0]      index_q;
	logic signed [DATA_W-1:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= '0;
			issue_s2 <= '0;
		end else begin
			issue_s1 <= issue;
			issue_s2 <= issue_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(a_s1) * PROD_W'(b_s1);
	end

	always_comb begin
		term_c = prod_s2 >>> FRAC_BITS;
		sum_c  = (issue_s2.first ? ACC_W'(0) : acc_q) + ACC_W'(term_c);
		hi_c   = sum_c[ACC_W-1:DATA_W-1];
		if (hi_c == '0 || hi_c == '1) begin
			sat_c = sum_c[DATA_W-1:0];
		end else if (sum_c[ACC_W-1]) begin
			sat_c = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			sat_c = {1'b0, {(DATA_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (issue_s2.valid) begin
			acc_q <= sum_c;
		end
		if (issue_s2.valid && issue_s2.last) begin
			index_q <= IDX_IN_W'(issue_s2.flat);
			value_q <= sat_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			valid_q <= issue_s2.valid && issue_s2.last;
			last_q  <= issue_s2.valid && issue_s2.last && issue_s2.final_cell;
		end
	end

	assign result_valid = valid_q;
	assign result_index = index_q;
	assign result_value = value_q;
	assign last_result  = last_q;

endmodule

// ===== hdl/m4mul_ctrl.sv =====
// ----------------------------------------------------------------------------
// m4mul_ctrl
// Sequencer: walks column, row and inner index, issuing one
// multiply-accumulate per cycle, then waits for the pipeline to empty.
// ----------------------------------------------------------------------------
module m4mul_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic              drain_done,
	output logic              busy,
	output m4mul_pkg::issue_t issue
);
	import m4mul_pkg::*;

	state_t            state_q;
	state_t            state_d;
	logic [RC_W-1:0]   k_q;
	logic [RC_W-1:0]   row_q;
	logic [RC_W-1:0]   col_q;
	logic              k_end;
	logic              row_end;
	logic              col_end;

	assign k_end   = (k_q == RC_W'(DIM - 1));
	assign row_end = (row_q == RC_W'(DIM - 1));
	assign col_end = (col_q == RC_W'(DIM - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			row_q   <= '0;
			col_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_RUN) begin
				k_q <= k_end ? '0 : k_q + 1'b1;
				if (k_end) begin
					row_q <= row_end ? '0 : row_q + 1'b1;
					if (row_end) begin
						col_q <= col_end ? '0 : col_q + 1'b1;
					end
				end
			end else begin
				k_q   <= '0;
				row_q <= '0;
				col_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (go) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (k_end && row_end && col_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy             = (state_q != ST_IDLE);
		issue.valid      = (state_q == ST_RUN);
		issue.first      = (k_q == '0);
		issue.last       = k_end;
		issue.final_cell = row_end && col_end;
		issue.a_addr     = ADDR_W'(ADDR_W'(k_q) * ADDR_W'(DIM) + ADDR_W'(row_q));
		issue.b_addr     = ADDR_W'(ADDR_W'(col_q) * ADDR_W'(DIM) + ADDR_W'(k_q));
		issue.flat       = ADDR_W'(ADDR_W'(col_q) * ADDR_W'(DIM) + ADDR_W'(row_q));
	end

endmodule
